// File: design/fbpe_pkg.sv
`default_nettype none

package fbpe_pkg;

    // Field and register widths.
    localparam int WidthW    = 11;
    localparam int CoordW    = 10;
    localparam int OffW      = 7;
    localparam int PadW      = 8;
    localparam int ByteW     = 8;
    localparam int RowBytesW = 9;
    localparam int StrideW   = 10;
    localparam int ProdW     = WidthW + StrideW;
    localparam int AddrSumW  = ProdW + 1;
    localparam int PixBits   = 3;

    // Bus widths.
    localparam int ApbAddrW  = 4;
    localparam int ApbDataW  = 32;
    localparam int InTdataW  = 32;
    localparam int OutTdataW = 16;
    localparam int OutUsedW  = 1 + ByteW + 1;

    // Bit positions of the request fields in the slave-side tdata.
    localparam int CmdLsb = 0;
    localparam int XLsb   = 3;
    localparam int YLsb   = XLsb + CoordW;
    localparam int ValBit = YLsb + CoordW;
    localparam int OffLsb = ValBit + 1;

    localparam logic [WidthW-1:0] WidthReset  = 11'd128;
    localparam logic [WidthW-1:0] HeightReset = 11'd64;

    typedef enum logic [2:0] {
        CMD_WRITE    = 3'd0,
        CMD_READ     = 3'd1,
        CMD_TOGGLE   = 3'd2,
        CMD_CLEAR    = 3'd3,
        CMD_ROW_BYTE = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        REG_WIDTH   = 2'd0,
        REG_HEIGHT  = 2'd1,
        REG_PORCH   = 2'd2,
        REG_TRAILER = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [WidthW-1:0]    width;
        logic [WidthW-1:0]    height;
        logic [PadW-1:0]      porch;
        logic [PadW-1:0]      trailer;
        logic [RowBytesW-1:0] row_bytes;
        logic [StrideW-1:0]   stride;
    } t_cfg;

    typedef struct packed {
        logic [AddrSumW-1:0] addr;
        logic                err;
    } t_agen;

endpackage

`default_nettype wire

// File: design/mono_framebuffer_pixel_engine_top.sv
// A pixel or row byte request reads the frame memory in the address state and is done
// in the data state, where its result is registered; a request out of range or with
// an unknown command is answered from the address state. Requests are worked one at a
// time; a clear zeroes the first height_rows*stride bytes (at most MEM_BYTES).
// Reset (synchronous, active low) idles the control logic and restores the register
// defaults; the frame memory holds nothing defined until written or cleared.
`default_nettype none

module mono_framebuffer_pixel_engine_top #(
    parameter int MEM_BYTES = 4096
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // cmd[2:0], x_coord[12:3], y_coord[22:13], pixel_value[23], byte_offset[30:24]
    input  wire logic [fbpe_pkg::InTdataW-1:0]   s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // pixel_out[0], byte_out[8:1], status[9]
    output logic      [fbpe_pkg::OutTdataW-1:0]  m_axis_tdata,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [fbpe_pkg::ApbAddrW-1:0]   paddr,
    input  wire logic [fbpe_pkg::ApbDataW-1:0]   pwdata,
    output logic      [fbpe_pkg::ApbDataW-1:0]   prdata,
    output logic                                 pready
);
    import fbpe_pkg::*;

    localparam int AddrW = $clog2(MEM_BYTES);
    localparam int PtrW  = $clog2(MEM_BYTES + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADDR,
        ST_DATA,
        ST_CLEAR
    } t_state;

    t_state              r_state;
    t_cmd                r_cmd;
    logic [CoordW-1:0]   r_x;
    logic [CoordW-1:0]   r_y;
    logic                r_val;
    logic [OffW-1:0]     r_off;
    logic [AddrW-1:0]    r_addr;
    logic [PtrW-1:0]     r_ptr;
    logic [PtrW-1:0]     r_total;
    logic                r_clr_err;
    logic                r_out_valid;
    logic                r_pix;
    logic [ByteW-1:0]    r_byte;
    logic                r_status;

    t_cfg                cfg;
    t_agen               agen;
    logic                in_acc;
    logic                out_free;
    logic                out_load;
    logic                needs_read;
    logic                do_write;
    logic [ByteW-1:0]    rd_data;
    logic [ByteW-1:0]    mask;
    logic [ByteW-1:0]    mod_byte;
    logic                mem_we;
    logic [AddrW-1:0]    mem_waddr;
    logic [ByteW-1:0]    mem_wdata;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;

    // A new result is loaded into the output register this cycle.
    assign out_load = out_free
                   && (((r_state == ST_ADDR) && (r_cmd != CMD_CLEAR) && agen.err)
                       || (r_state == ST_DATA)
                       || ((r_state == ST_CLEAR) && (r_ptr == r_total)));

    fbpe_cfg u_cfg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_pready  (pready),
        .o_cfg     (cfg)
    );

    fbpe_agen #(
        .MEM_BYTES (MEM_BYTES)
    ) u_agen (
        .i_clk     (i_clk),
        .i_load    (in_acc),
        .i_cmd     (t_cmd'(s_axis_tdata[CmdLsb +: 3])),
        .i_y       (s_axis_tdata[YLsb +: CoordW]),
        .i_cfg     (cfg),
        .i_req_cmd (r_cmd),
        .i_req_x   (r_x),
        .i_req_y   (r_y),
        .i_req_off (r_off),
        .o_agen    (agen)
    );

    always_comb begin
        case (r_cmd)
            CMD_WRITE, CMD_READ, CMD_TOGGLE, CMD_ROW_BYTE: needs_read = 1'b1;
            default:                                       needs_read = 1'b0;
        endcase
    end

    assign mask = ByteW'(1) << r_x[PixBits-1:0];

    always_comb begin
        mod_byte = rd_data;
        do_write = 1'b0;
        case (r_cmd)
            CMD_WRITE: begin
                mod_byte = r_val ? (rd_data | mask) : (rd_data & ~mask);
                do_write = 1'b1;
            end
            CMD_TOGGLE: begin
                mod_byte = rd_data ^ mask;
                do_write = 1'b1;
            end
            default: ;
        endcase
    end

    // The write-back lands together with the result, so no later read can overtake it.
    assign mem_we    = ((r_state == ST_DATA) && out_free && do_write)
                    || ((r_state == ST_CLEAR) && (r_ptr != r_total));
    assign mem_waddr = (r_state == ST_CLEAR) ? r_ptr[AddrW-1:0] : r_addr;
    assign mem_wdata = (r_state == ST_CLEAR) ? '0 : mod_byte;

    fbpe_ram #(
        .Width (ByteW),
        .Depth (MEM_BYTES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    ((r_state == ST_ADDR) && needs_read && !agen.err),
        .i_raddr (agen.addr[AddrW-1:0]),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_ptr       <= '0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tvalid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_cmd   <= t_cmd'(s_axis_tdata[CmdLsb +: 3]);
                        r_x     <= s_axis_tdata[XLsb +: CoordW];
                        r_y     <= s_axis_tdata[YLsb +: CoordW];
                        r_val   <= s_axis_tdata[ValBit];
                        r_off   <= s_axis_tdata[OffLsb +: OffW];
                        r_state <= ST_ADDR;
                    end
                end
                ST_ADDR: begin
                    if (r_cmd == CMD_CLEAR) begin
                        r_total   <= agen.addr[PtrW-1:0];
                        r_clr_err <= agen.err;
                        r_ptr     <= '0;
                        r_state   <= ST_CLEAR;
                    end else if (agen.err) begin
                        if (out_free) begin
                            r_pix       <= 1'b0;
                            r_byte      <= '0;
                            r_status    <= 1'b1;
                            r_state     <= ST_IDLE;
                        end
                    end else begin
                        r_addr  <= agen.addr[AddrW-1:0];
                        r_state <= ST_DATA;
                    end
                end
                ST_DATA: begin
                    if (out_free) begin
                        r_pix       <= (r_cmd == CMD_READ) && ((rd_data & mask) != '0);
                        r_byte      <= (r_cmd == CMD_ROW_BYTE) ? rd_data : '0;
                        r_status    <= 1'b0;
                        r_state     <= ST_IDLE;
                    end
                end
                ST_CLEAR: begin
                    if (r_ptr != r_total) begin
                        r_ptr <= r_ptr + PtrW'(1);
                    end else if (out_free) begin
                        r_pix       <= 1'b0;
                        r_byte      <= '0;
                        r_status    <= r_clr_err;
                        r_ptr       <= '0;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OutTdataW'({r_status, r_byte, r_pix});

endmodule

`default_nettype wire

// File: design/fbpe_ram.sv
`default_nettype none

module fbpe_ram #(
    parameter int Width = 8,
    parameter int Depth = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(Depth)-1:0] i_waddr,
    input  wire logic [Width-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(Depth)-1:0] i_raddr,
    output logic      [Width-1:0]         o_rdata
);

    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: design/fbpe_cfg.sv
`default_nettype none

module fbpe_cfg (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_psel,
    input  wire logic                           i_penable,
    input  wire logic                           i_pwrite,
    input  wire logic [fbpe_pkg::ApbAddrW-1:0]  i_paddr,
    input  wire logic [fbpe_pkg::ApbDataW-1:0]  i_pwdata,
    output logic      [fbpe_pkg::ApbDataW-1:0]  o_prdata,
    output logic                                o_pready,
    output fbpe_pkg::t_cfg                      o_cfg
);
    import fbpe_pkg::*;

    logic [WidthW-1:0]   r_width;
    logic [WidthW-1:0]   r_height;
    logic [PadW-1:0]     r_porch;
    logic [PadW-1:0]     r_trailer;
    logic                wr_en;
    t_reg_idx            reg_idx;
    logic [WidthW:0]     width_round;
    logic [RowBytesW-1:0] row_bytes;

    assign o_pready = 1'b1;
    assign wr_en    = i_psel && i_penable && i_pwrite && o_pready;
    assign reg_idx  = t_reg_idx'(i_paddr[ApbAddrW-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= WidthReset;
            r_height  <= HeightReset;
            r_porch   <= '0;
            r_trailer <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_WIDTH:   r_width   <= i_pwdata[WidthW-1:0];
                REG_HEIGHT:  r_height  <= i_pwdata[WidthW-1:0];
                REG_PORCH:   r_porch   <= i_pwdata[PadW-1:0];
                REG_TRAILER: r_trailer <= i_pwdata[PadW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_WIDTH:   o_prdata = ApbDataW'(r_width);
            REG_HEIGHT:  o_prdata = ApbDataW'(r_height);
            REG_PORCH:   o_prdata = ApbDataW'(r_porch);
            REG_TRAILER: o_prdata = ApbDataW'(r_trailer);
            default:     o_prdata = '0;
        endcase
    end

    // Pixel bytes per row round the width up to whole bytes.
    assign width_round = (WidthW + 1)'(r_width) + (WidthW + 1)'(7);
    assign row_bytes   = width_round[WidthW:PixBits];

    assign o_cfg.width     = r_width;
    assign o_cfg.height    = r_height;
    assign o_cfg.porch     = r_porch;
    assign o_cfg.trailer   = r_trailer;
    assign o_cfg.row_bytes = row_bytes;
    assign o_cfg.stride    = StrideW'(row_bytes) + StrideW'(r_porch) + StrideW'(r_trailer);

endmodule

`default_nettype wire

// File: design/fbpe_agen.sv
`default_nettype none

module fbpe_agen #(
    parameter int MEM_BYTES = 4096
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_load,
    input  wire fbpe_pkg::t_cmd               i_cmd,
    input  wire logic [fbpe_pkg::CoordW-1:0]  i_y,
    input  wire fbpe_pkg::t_cfg               i_cfg,
    input  wire fbpe_pkg::t_cmd               i_req_cmd,
    input  wire logic [fbpe_pkg::CoordW-1:0]  i_req_x,
    input  wire logic [fbpe_pkg::CoordW-1:0]  i_req_y,
    input  wire logic [fbpe_pkg::OffW-1:0]    i_req_off,
    output fbpe_pkg::t_agen                   o_agen
);
    import fbpe_pkg::*;

    localparam logic [AddrSumW-1:0] MemLimit = AddrSumW'(MEM_BYTES);

    logic [WidthW-1:0]   mul_a;
    logic [ProdW-1:0]    r_prod;
    logic [AddrSumW-1:0] prod_ext;
    logic [AddrSumW-1:0] sum_pix;
    logic [AddrSumW-1:0] sum_row;
    logic                y_out;
    logic                over;

    // A clear multiplies the height by the stride, every other request its row.
    assign mul_a = (i_cmd == CMD_CLEAR) ? i_cfg.height : WidthW'(i_y);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_prod <= ProdW'(mul_a) * ProdW'(i_cfg.stride);
        end
    end

    assign prod_ext = AddrSumW'(r_prod);
    assign sum_pix  = prod_ext + AddrSumW'(i_cfg.porch)
                    + AddrSumW'(i_req_x[CoordW-1:PixBits]);
    assign sum_row  = prod_ext + AddrSumW'(i_cfg.porch) + AddrSumW'(i_req_off);
    assign y_out    = WidthW'(i_req_y) >= i_cfg.height;
    assign over     = prod_ext > MemLimit;

    always_comb begin
        case (i_req_cmd)
            CMD_WRITE, CMD_READ, CMD_TOGGLE: begin
                o_agen.addr = sum_pix;
                o_agen.err  = (WidthW'(i_req_x) >= i_cfg.width) || y_out
                            || (sum_pix >= MemLimit);
            end
            CMD_ROW_BYTE: begin
                o_agen.addr = sum_row;
                o_agen.err  = (RowBytesW'(i_req_off) >= i_cfg.row_bytes) || y_out
                            || (sum_row >= MemLimit);
            end
            CMD_CLEAR: begin
                // The sweep length is capped at the memory size.
                o_agen.addr = over ? MemLimit : prod_ext;
                o_agen.err  = over;
            end
            default: begin
                o_agen.addr = sum_pix;
                o_agen.err  = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: design/fbpe_chk.sv
`default_nettype none

module fbpe_chk (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            s_axis_tvalid,
    input wire logic                            s_axis_tready,
    input wire logic                            m_axis_tvalid,
    input wire logic                            m_axis_tready,
    input wire logic [fbpe_pkg::OutTdataW-1:0]  m_axis_tdata
);
    import fbpe_pkg::*;

    // A result that is not taken stays on the bus unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // Requests are worked one at a time, so no request follows directly on another.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request accepted while the previous one is in progress");

    // A lit pixel comes only from a successful pixel read, which carries no byte.
    a_pixel_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[OutUsedW-1:1] == '0)
        else $error("pixel result carries a byte or an error");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[OutTdataW-1:OutUsedW] == '0)
        else $error("padding bits of the result are not zero");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result presented straight after reset");

endmodule

bind mono_framebuffer_pixel_engine_top fbpe_chk u_fbpe_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// File: test/fbpe_checker.sv
`timescale 1ns / 100ps

module fbpe_checker #(
    parameter int MemBytes = 4096
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              s_axis_tvalid,
    input  wire logic                              s_axis_tready,
    // cmd[2:0], x_coord[12:3], y_coord[22:13], pixel_value[23], byte_offset[30:24]
    input  wire logic [fbpe_pkg::InTdataW-1:0]     s_axis_tdata,
    input  wire logic                              m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // pixel_out[0], byte_out[8:1], status[9]
    input  wire logic [fbpe_pkg::OutTdataW-1:0]    m_axis_tdata,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [fbpe_pkg::ApbAddrW-1:0]     paddr,
    input  wire logic [fbpe_pkg::ApbDataW-1:0]     pwdata,
    input  wire logic [fbpe_pkg::ApbDataW-1:0]     prdata,
    input  wire logic                              pready,
    output int                                     o_fail_count,
    output int                                     o_outstanding
);

    import fbpe_pkg::*;

    typedef struct packed {
        logic [2:0]        cmd;
        logic [CoordW-1:0] x;
        logic [CoordW-1:0] y;
        logic              val;
        logic [OffW-1:0]   off;
    } t_pixel_request;

    typedef struct packed {
        logic             pixel;
        logic [ByteW-1:0] data_byte;
        logic             status;
    } t_pixel_result;

    logic [WidthW-1:0] cfg_width;
    logic [WidthW-1:0] cfg_height;
    logic [PadW-1:0]   cfg_porch;
    logic [PadW-1:0]   cfg_trailer;

    logic [ByteW-1:0]  frame_bytes [MemBytes];
    t_pixel_result     expected_results [$];

    task automatic note_mismatch(input string what);
        if (o_fail_count < 40) begin
            $display("MISMATCH at %0t ns: %s", $time, what);
        end
        o_fail_count++;
    endtask

    // Applies one request to the shadow frame memory and returns the response it should give.
    function automatic t_pixel_result apply_command(input t_pixel_request req);
        int unsigned   row_len;
        int unsigned   stride;
        int unsigned   addr;
        int unsigned   total;
        int unsigned   i;
        logic [7:0]    bit_mask;
        t_pixel_result res;
        res      = '0;
        row_len  = (32'(cfg_width) + 7) / 8;
        stride   = row_len + cfg_porch + cfg_trailer;
        bit_mask = 8'd1 << req.x[2:0];
        case (req.cmd)
            CMD_WRITE, CMD_READ, CMD_TOGGLE: begin
                addr = req.y * stride + cfg_porch + req.x / 8;
                if (req.x >= cfg_width || req.y >= cfg_height || addr >= MemBytes) begin
                    res.status = 1'b1;
                end else if (req.cmd == CMD_WRITE) begin
                    if (req.val) begin
                        frame_bytes[addr] = frame_bytes[addr] | bit_mask;
                    end else begin
                        frame_bytes[addr] = frame_bytes[addr] & ~bit_mask;
                    end
                end else if (req.cmd == CMD_READ) begin
                    res.pixel = |(frame_bytes[addr] & bit_mask);
                end else begin
                    frame_bytes[addr] = frame_bytes[addr] ^ bit_mask;
                end
            end
            CMD_CLEAR: begin
                total = cfg_height * stride;
                // A sweep larger than the memory stops at its end and is flagged.
                if (total > MemBytes) begin
                    total      = MemBytes;
                    res.status = 1'b1;
                end
                for (i = 0; i < total; i++) begin
                    frame_bytes[i] = '0;
                end
            end
            CMD_ROW_BYTE: begin
                addr = req.y * stride + cfg_porch + req.off;
                if (req.off >= row_len || req.y >= cfg_height || addr >= MemBytes) begin
                    res.status = 1'b1;
                end else begin
                    res.data_byte = frame_bytes[addr];
                end
            end
            default: begin
                res.status = 1'b1;
            end
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_pixel_request    req;
        t_pixel_result     got;
        t_pixel_result     want;
        logic [ApbDataW-1:0] reg_value;
        if (!i_rst_n) begin
            cfg_width   = WidthReset;
            cfg_height  = HeightReset;
            cfg_porch   = '0;
            cfg_trailer = '0;
            expected_results.delete();
            o_outstanding <= 0;
        end else begin
            // Responses are retired before new requests are predicted, since a response
            // can never belong to a request accepted at the same edge.
            if (m_axis_tvalid && m_axis_tready) begin
                got.pixel     = m_axis_tdata[0];
                got.data_byte = m_axis_tdata[ByteW:1];
                got.status    = m_axis_tdata[ByteW+1];
                if (expected_results.size() == 0) begin
                    note_mismatch($sformatf("response %h with no request waiting", m_axis_tdata));
                end else begin
                    want = expected_results.pop_front();
                    if (got.pixel !== want.pixel) begin
                        note_mismatch($sformatf("pixel_out %b, expected %b",
                                                got.pixel, want.pixel));
                    end
                    if (got.data_byte !== want.data_byte) begin
                        note_mismatch($sformatf("byte_out %h, expected %h",
                                                got.data_byte, want.data_byte));
                    end
                    if (got.status !== want.status) begin
                        note_mismatch($sformatf("status %b, expected %b",
                                                got.status, want.status));
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                req.cmd = s_axis_tdata[CmdLsb +: 3];
                req.x   = s_axis_tdata[XLsb +: CoordW];
                req.y   = s_axis_tdata[YLsb +: CoordW];
                req.val = s_axis_tdata[ValBit];
                req.off = s_axis_tdata[OffLsb +: OffW];
                expected_results.push_back(apply_command(req));
            end
            if (psel && penable && pready) begin
                if (pwrite) begin
                    case (t_reg_idx'(paddr[3:2]))
                        REG_WIDTH:   cfg_width   = pwdata[WidthW-1:0];
                        REG_HEIGHT:  cfg_height  = pwdata[WidthW-1:0];
                        REG_PORCH:   cfg_porch   = pwdata[PadW-1:0];
                        REG_TRAILER: cfg_trailer = pwdata[PadW-1:0];
                        default: ;
                    endcase
                end else begin
                    case (t_reg_idx'(paddr[3:2]))
                        REG_WIDTH:   reg_value = ApbDataW'(cfg_width);
                        REG_HEIGHT:  reg_value = ApbDataW'(cfg_height);
                        REG_PORCH:   reg_value = ApbDataW'(cfg_porch);
                        default:     reg_value = ApbDataW'(cfg_trailer);
                    endcase
                    if (prdata !== reg_value) begin
                        note_mismatch($sformatf("register at %h reads %h, expected %h",
                                                paddr, prdata, reg_value));
                    end
                end
            end
            o_outstanding <= expected_results.size();
        end
    end

endmodule

// File: test/mono_framebuffer_pixel_engine_top_tb.sv
`timescale 1ns / 100ps

module mono_framebuffer_pixel_engine_top_tb;

    import fbpe_pkg::*;

    localparam int         MemBytes       = 4096;
    localparam int         IdleLimit      = 20000;
    localparam logic [2:0] CmdFirstUnused = 3'd5;
    localparam logic [2:0] CmdLastUnused  = 3'd7;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    // cmd[2:0], x_coord[12:3], y_coord[22:13], pixel_value[23], byte_offset[30:24]
    logic [InTdataW-1:0]  s_axis_tdata  = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // pixel_out[0], byte_out[8:1], status[9]
    logic [OutTdataW-1:0] m_axis_tdata;
    logic                 psel          = 1'b0;
    logic                 penable       = 1'b0;
    logic                 pwrite        = 1'b0;
    logic [ApbAddrW-1:0]  paddr         = '0;
    logic [ApbDataW-1:0]  pwdata        = '0;
    logic [ApbDataW-1:0]  prdata;
    logic                 pready;

    int fail_count;
    int pending_count;
    int send_idle_pct = 9;
    int recv_idle_pct = 60;
    int idle_cycles   = 0;
    int requests_sent = 0;
    int clears_sent   = 0;
    int settings_used = 0;
    int cur_w         = 128;
    int cur_h         = 64;

    always #10 i_clk = ~i_clk;

    mono_framebuffer_pixel_engine_top #(
        .MEM_BYTES(MemBytes)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    fbpe_checker #(
        .MemBytes(MemBytes)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_fail_count  (fail_count),
        .o_outstanding (pending_count)
    );

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Ends the run if nothing moves on any channel for too long.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (psel && penable) || !i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IdleLimit) begin
            $display("watchdog: no traffic for %0d cycles", IdleLimit);
            $display("tb: failure");
            $finish;
        end
    end

    function automatic int pick_below(input int n);
        return (n <= 0) ? 0 : int'($urandom_range(n - 1, 0));
    endfunction

    task automatic send_request(input logic [2:0] cmd, input logic [CoordW-1:0] x,
                                input logic [CoordW-1:0] y, input logic val,
                                input logic [OffW-1:0] off);
        logic [InTdataW-1:0] word;
        word                    = '0;
        word[CmdLsb +: 3]       = cmd;
        word[XLsb +: CoordW]    = x;
        word[YLsb +: CoordW]    = y;
        word[ValBit]            = val;
        word[OffLsb +: OffW]    = off;
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
        requests_sent++;
        if (cmd == CMD_CLEAR) begin
            clears_sent++;
        end
    endtask

    // Drops the request stream and waits until every response is back and the block is quiet.
    task automatic drain;
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) begin
            @(posedge i_clk);
        end
        repeat (6) @(posedge i_clk);
    endtask

    task automatic apb_access(input logic wr, input t_reg_idx idx,
                              input logic [ApbDataW-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure(input int w, input int h, input int porch, input int trailer);
        drain();
        apb_access(1'b1, REG_WIDTH, ApbDataW'(w));
        apb_access(1'b1, REG_HEIGHT, ApbDataW'(h));
        apb_access(1'b1, REG_PORCH, ApbDataW'(porch));
        apb_access(1'b1, REG_TRAILER, ApbDataW'(trailer));
        apb_access(1'b0, REG_WIDTH, '0);
        apb_access(1'b0, REG_HEIGHT, '0);
        apb_access(1'b0, REG_PORCH, '0);
        apb_access(1'b0, REG_TRAILER, '0);
        cur_w = w;
        cur_h = h;
        settings_used++;
    endtask

    initial begin : stimulus
        int         kind;
        int         cmd_sel;
        int         spot;
        int         w;
        int         h;
        int         porch;
        int         trailer;
        int         row_len;
        logic [2:0] cmd;
        logic [9:0] x;
        logic [9:0] y;
        logic [6:0] off;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset defaults: the clear covers every byte a 128 by 64 display can reach.
        apb_access(1'b0, REG_WIDTH, '0);
        apb_access(1'b0, REG_HEIGHT, '0);
        apb_access(1'b0, REG_PORCH, '0);
        apb_access(1'b0, REG_TRAILER, '0);
        send_request(CMD_CLEAR, 10'd0, 10'd0, 1'b0, 7'd0);
        send_request(CMD_WRITE, 10'd0, 10'd0, 1'b1, 7'd0);
        send_request(CMD_READ, 10'd0, 10'd0, 1'b0, 7'd0);
        send_request(CMD_WRITE, 10'd127, 10'd63, 1'b1, 7'd0);
        send_request(CMD_TOGGLE, 10'd127, 10'd63, 1'b0, 7'd0);
        send_request(CMD_READ, 10'd127, 10'd63, 1'b1, 7'd0);
        send_request(CMD_WRITE, 10'd0, 10'd0, 1'b0, 7'd0);
        send_request(CMD_READ, 10'd0, 10'd0, 1'b0, 7'd0);
        send_request(CMD_ROW_BYTE, 10'd0, 10'd63, 1'b0, 7'd15);
        send_request(CMD_ROW_BYTE, 10'd0, 10'd0, 1'b0, 7'd16);
        send_request(CMD_WRITE, 10'd128, 10'd0, 1'b1, 7'd0);
        send_request(CMD_READ, 10'd0, 10'd64, 1'b0, 7'd0);
        send_request(CmdFirstUnused, 10'h3FF, 10'h3FF, 1'b1, 7'h7F);
        send_request(CmdLastUnused, 10'h3FF, 10'h3FF, 1'b1, 7'h7F);

        // Full-width display: the clear overruns the memory and sweeps all of it.
        configure(1024, 64, 0, 0);
        send_request(CMD_CLEAR, 10'd0, 10'd0, 1'b0, 7'd0);
        send_request(CMD_WRITE, 10'd1023, 10'd31, 1'b1, 7'd0);
        send_request(CMD_READ, 10'd1023, 10'd31, 1'b0, 7'd0);
        send_request(CMD_READ, 10'd1023, 10'd32, 1'b0, 7'd0);

        configure(2047, 2047, 255, 255);
        send_request(CMD_CLEAR, 10'd0, 10'd0, 1'b0, 7'd0);
        send_request(CMD_TOGGLE, 10'd1023, 10'd0, 1'b0, 7'd0);
        send_request(CMD_ROW_BYTE, 10'd0, 10'd1, 1'b0, 7'd127);

        configure(0, 0, 0, 0);
        send_request(CMD_WRITE, 10'd0, 10'd0, 1'b1, 7'd0);
        send_request(CMD_CLEAR, 10'd0, 10'd0, 1'b0, 7'd0);
        send_request(CMD_ROW_BYTE, 10'd0, 10'd0, 1'b0, 7'd0);

        for (int setting = 0; setting < 16; setting++) begin
            if (setting == 5) begin
                send_idle_pct <= 60;
                recv_idle_pct <= 9;
            end else if (setting == 10) begin
                send_idle_pct <= 0;
                recv_idle_pct <= 0;
            end
            kind = $urandom_range(9);
            if (kind <= 6) begin
                w       = $urandom_range(64, 1);
                h       = $urandom_range(32, 1);
                porch   = $urandom_range(6, 0);
                trailer = $urandom_range(6, 0);
            end else if (kind == 7) begin
                w       = $urandom_range(1024, 65);
                h       = $urandom_range(64, 1);
                porch   = $urandom_range(40, 0);
                trailer = $urandom_range(40, 0);
            end else if (kind == 8) begin
                case ($urandom_range(3))
                    0:       w = 0;
                    1:       w = 1;
                    2:       w = 1024;
                    default: w = 2047;
                endcase
                case ($urandom_range(3))
                    0:       h = 0;
                    1:       h = 1;
                    2:       h = 1024;
                    default: h = 2047;
                endcase
                porch   = $urandom_range(1) ? 255 : 0;
                trailer = $urandom_range(1) ? 255 : 0;
            end else begin
                w       = $urandom_range(2047, 0);
                h       = $urandom_range(2047, 0);
                porch   = $urandom_range(255, 0);
                trailer = $urandom_range(255, 0);
            end
            configure(w, h, porch, trailer);
            row_len = (w + 7) / 8;

            for (int n = 0; n < 100; n++) begin
                cmd_sel = $urandom_range(99);
                if (cmd_sel < 30) begin
                    cmd = CMD_WRITE;
                end else if (cmd_sel < 55) begin
                    cmd = CMD_READ;
                end else if (cmd_sel < 70) begin
                    cmd = CMD_TOGGLE;
                end else if (cmd_sel < 88) begin
                    cmd = CMD_ROW_BYTE;
                end else if (cmd_sel < 91) begin
                    cmd = CMD_CLEAR;
                end else if (cmd_sel < 96) begin
                    cmd = 3'($urandom_range(CmdLastUnused, CmdFirstUnused));
                end else begin
                    cmd = 3'($urandom);
                end
                // Most requests land in a small corner so that reads see earlier writes.
                spot = $urandom_range(9);
                if (spot < 6) begin
                    x   = 10'(pick_below((cur_w < 16) ? cur_w : 16));
                    y   = 10'(pick_below((cur_h < 4) ? cur_h : 4));
                    off = 7'(pick_below((row_len < 4) ? row_len : 4));
                end else if (spot < 8) begin
                    x   = 10'(pick_below((cur_w < 1024) ? cur_w : 1024));
                    y   = 10'(pick_below((cur_h < 1024) ? cur_h : 1024));
                    off = 7'(pick_below((row_len < 128) ? row_len : 128));
                end else begin
                    x   = 10'($urandom);
                    y   = 10'($urandom);
                    off = 7'($urandom);
                end
                send_request(cmd, x, y, 1'($urandom), off);
            end
        end

        drain();
        $display("summary: %0d requests, %0d of them clears, over %0d register settings",
                 requests_sent, clears_sent, settings_used);
        $display("summary: sender and receiver stalls swapped part way, last part unstalled");
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// File: filelist.f
design/fbpe_pkg.sv
design/fbpe_ram.sv
design/fbpe_cfg.sv
design/fbpe_agen.sv
design/mono_framebuffer_pixel_engine_top.sv
design/fbpe_chk.sv
test/fbpe_checker.sv
test/mono_framebuffer_pixel_engine_top_tb.sv
